// ===== sv/ptt_pkg.sv =====
// Shared types and constants for the periodic task timer table.
`default_nettype none

package ptt_pkg;

   localparam int NUM_CHANNELS = 10;

   localparam int TIME_W     = 32;
   localparam int PERIOD_W   = 16;
   localparam int DELAY_W    = 16;
   localparam int MS_W       = 16;
   localparam int MASK_W     = 10;
   localparam int CHAN_IDX_W = 4;

   // scan index addresses one entry, count must also hold NUM_CHANNELS itself
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
   localparam int MASK_PAD_W = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture the request fields
      logic setup;  // apply the add or advance the clock, arm the scan
      logic scan;   // process the entry at the scan index
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/ptt_ctrl.sv =====
// Sequencer for the timer table: accept, setup, channel scan, drain, respond.
`default_nettype none

module ptt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire ptt_pkg::stat_type stat,
   output ptt_pkg::ctrl_type      ctrl,
   output logic                   busy,
   output logic                   rsp_strobe
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      ctrl       = '0;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            ctrl.setup = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            ctrl.scan = 1'b1;
            if (stat.scan_last) state_in = ST_DRAIN;
         end
         // last entry's minimum compare completes here
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_done_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("result strobe not followed by idle");

   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SETUP))
      else $error("accepted item did not enter setup");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

endmodule

`default_nettype wire

// ===== sv/ptt_dp.sv =====
// Timer table datapath: clock, channel entries, fire update and earliest-due search.
`default_nettype none

module ptt_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ptt_pkg::ctrl_type                  ctrl,
   input  wire logic                               req_command,
   input  wire logic [ptt_pkg::PERIOD_W-1:0]       req_period_ms,
   input  wire logic [ptt_pkg::DELAY_W-1:0]        req_start_delay_ms,
   output ptt_pkg::stat_type                       stat,
   output logic [ptt_pkg::MASK_W-1:0]              rsp_fired_mask,
   output logic [ptt_pkg::CHAN_IDX_W-1:0]          rsp_channel_index,
   output logic                                    rsp_add_rejected,
   output logic [ptt_pkg::MS_W-1:0]                rsp_ms_until_next,
   output logic                                    rsp_any_channel
);

   localparam int N = ptt_pkg::NUM_CHANNELS;

   // request capture
   logic                          cmd_ff, cmd_in;
   logic [ptt_pkg::PERIOD_W-1:0]  req_per_ff, req_per_in;
   logic [ptt_pkg::DELAY_W-1:0]   req_dly_ff, req_dly_in;

   // block state
   logic [ptt_pkg::TIME_W-1:0]    time_ff, time_in;
   logic [ptt_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [ptt_pkg::TIME_W-1:0]    due_ff [N];
   logic [ptt_pkg::TIME_W-1:0]    due_in [N];
   logic [ptt_pkg::PERIOD_W-1:0]  per_ff [N];
   logic [ptt_pkg::PERIOD_W-1:0]  per_in [N];

   // scan and result
   logic [ptt_pkg::IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [N-1:0]                   mask_ff, mask_in;
   logic [ptt_pkg::CHAN_IDX_W-1:0] index_ff, index_in;
   logic                           rejected_ff, rejected_in;
   logic                           p2_valid_ff, p2_valid_in;
   logic [ptt_pkg::TIME_W-1:0]     p2_due_ff, p2_due_in;
   logic [ptt_pkg::TIME_W-1:0]     best_ff, best_in;
   logic                           have_ff, have_in;

   logic [ptt_pkg::IDX_W-1:0]      add_idx;
   logic                           table_full;
   logic                           active;
   logic [ptt_pkg::TIME_W-1:0]     rd_due;
   logic [ptt_pkg::PERIOD_W-1:0]   rd_per;
   logic [ptt_pkg::TIME_W-1:0]     late;
   logic                           fire;
   logic [ptt_pkg::PERIOD_W:0]     step;
   logic [ptt_pkg::TIME_W-1:0]     due_new;
   logic [ptt_pkg::TIME_W-1:0]     diff;
   logic [ptt_pkg::MASK_PAD_W-1:0] mask_pad;

   assign add_idx    = count_ff[ptt_pkg::IDX_W-1:0];
   assign table_full = (count_ff >= ptt_pkg::CNT_W'(N));
   assign active     = (ptt_pkg::CNT_W'(scan_idx_ff) < count_ff);
   assign rd_due     = due_ff[scan_idx_ff];
   assign rd_per     = per_ff[scan_idx_ff];

   // Every entry is checked on every tick, so an entry is never more than one
   // ms late; it needs two periods only when late by one with a period of one.
   assign late    = time_ff - rd_due;
   assign fire    = (cmd_ff == ptt_pkg::CMD_TICK) && active && !late[ptt_pkg::TIME_W-1];
   assign step    = (late >= ptt_pkg::TIME_W'(rd_per)) ? {rd_per, 1'b0} : {1'b0, rd_per};
   assign due_new = rd_due + ptt_pkg::TIME_W'(step);

   assign diff = p2_due_ff - time_ff;

   always_comb begin
      cmd_in      = cmd_ff;
      req_per_in  = req_per_ff;
      req_dly_in  = req_dly_ff;
      time_in     = time_ff;
      count_in    = count_ff;
      due_in      = due_ff;
      per_in      = per_ff;
      scan_idx_in = scan_idx_ff;
      mask_in     = mask_ff;
      index_in    = index_ff;
      rejected_in = rejected_ff;
      p2_valid_in = 1'b0;
      p2_due_in   = p2_due_ff;
      best_in     = best_ff;
      have_in     = have_ff;

      if (ctrl.load) begin
         cmd_in     = req_command;
         req_per_in = req_period_ms;
         req_dly_in = req_start_delay_ms;
      end

      if (ctrl.setup) begin
         scan_idx_in = '0;
         mask_in     = '0;
         index_in    = '0;
         rejected_in = 1'b0;
         have_in     = 1'b0;
         if (cmd_ff == ptt_pkg::CMD_TICK) begin
            time_in = time_ff + ptt_pkg::TIME_W'(1);
         end else if (table_full) begin
            rejected_in = 1'b1;
         end else begin
            per_in[add_idx] = (req_per_ff == '0) ? ptt_pkg::PERIOD_W'(1) : req_per_ff;
            due_in[add_idx] = time_ff + ptt_pkg::TIME_W'(req_dly_ff);
            index_in        = ptt_pkg::CHAN_IDX_W'(count_ff);
            count_in        = count_ff + ptt_pkg::CNT_W'(1);
         end
      end

      if (ctrl.scan) begin
         scan_idx_in = scan_idx_ff + ptt_pkg::IDX_W'(1);
         p2_valid_in = active;
         p2_due_in   = fire ? due_new : rd_due;
         if (fire) begin
            due_in[scan_idx_ff]  = due_new;
            mask_in[scan_idx_ff] = 1'b1;
         end
      end

      // second stage: running signed minimum of due minus now
      if (p2_valid_ff) begin
         if (!have_ff || ($signed(diff) < $signed(best_ff))) begin
            best_in = diff;
            have_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff     <= '0;
         count_ff    <= '0;
         p2_valid_ff <= 1'b0;
         have_ff     <= 1'b0;
         scan_idx_ff <= '0;
      end else begin
         time_ff     <= time_in;
         count_ff    <= count_in;
         p2_valid_ff <= p2_valid_in;
         have_ff     <= have_in;
         scan_idx_ff <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      req_per_ff  <= req_per_in;
      req_dly_ff  <= req_dly_in;
      due_ff      <= due_in;
      per_ff      <= per_in;
      mask_ff     <= mask_in;
      index_ff    <= index_in;
      rejected_ff <= rejected_in;
      p2_due_ff   <= p2_due_in;
      best_ff     <= best_in;
   end

   assign stat.scan_last = (scan_idx_ff == ptt_pkg::IDX_W'(N - 1));

   assign mask_pad          = ptt_pkg::MASK_PAD_W'(mask_ff);
   assign rsp_fired_mask    = mask_pad[ptt_pkg::MASK_W-1:0];
   assign rsp_channel_index = index_ff;
   assign rsp_add_rejected  = rejected_ff;
   assign rsp_any_channel   = (count_ff != '0);

   always_comb begin
      priority if (!have_ff) begin
         rsp_ms_until_next = '0;
      end else if ($signed(best_ff) < $signed(ptt_pkg::TIME_W'(1))) begin
         rsp_ms_until_next = ptt_pkg::MS_W'(1);
      end else if ($signed(best_ff) > $signed(ptt_pkg::TIME_W'(65535))) begin
         rsp_ms_until_next = '1;
      end else begin
         rsp_ms_until_next = best_ff[ptt_pkg::MS_W-1:0];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ptt_pkg::CNT_W'(N))
      else $error("channel count above table size");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (ctrl.setup && cmd_ff == ptt_pkg::CMD_TICK)
      |=> (time_ff == $past(time_ff) + ptt_pkg::TIME_W'(1)))
      else $error("tick did not advance the clock by one");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (ctrl.setup && cmd_ff == ptt_pkg::CMD_ADD && !table_full)
      |=> (count_ff == $past(count_ff) + ptt_pkg::CNT_W'(1)) && !rejected_ff)
      else $error("accepted add did not grow the table");

endmodule

`default_nettype wire

// ===== sv/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table.
//
// Request channel: drive req_command (0 = add a channel, 1 = one ms tick),
// req_period_ms and req_start_delay_ms with start high; the item is taken at
// the edge where start is high and busy is low.
// An add puts the channel in the next free slot with its first due time at
// now plus the delay; a full table reports add_rejected. A tick advances the
// ms clock, fires every due channel and moves its due time on by its period.
// Result channel: every item yields one result, shown for a single cycle
// with rsp_strobe high. The receiver cannot stall it; it must take it then.
// Sequence: after the accept edge come the setup state, the scan of every
// table slot at one entry per cycle, and the drain state that finishes the
// earliest-due compare; the done state then gives the strobe. busy falls
// after the strobe, so a new item is taken only once the last is done.
// Reset (synchronous, active high) clears the clock and the channel count;
// entries are written by adds before they are ever read.
`default_nettype none

module periodic_task_timer_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_command,
   input  wire logic [ptt_pkg::PERIOD_W-1:0]  req_period_ms,
   input  wire logic [ptt_pkg::DELAY_W-1:0]   req_start_delay_ms,
   output logic                               rsp_strobe,
   output logic [ptt_pkg::MASK_W-1:0]         rsp_fired_mask,
   output logic [ptt_pkg::CHAN_IDX_W-1:0]     rsp_channel_index,
   output logic                               rsp_add_rejected,
   output logic [ptt_pkg::MS_W-1:0]           rsp_ms_until_next,
   output logic                               rsp_any_channel
);

   ptt_pkg::ctrl_type ctrl;
   ptt_pkg::stat_type stat;

   ptt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .ctrl       (ctrl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ptt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .req_command        (req_command),
      .req_period_ms      (req_period_ms),
      .req_start_delay_ms (req_start_delay_ms),
      .stat               (stat),
      .rsp_fired_mask     (rsp_fired_mask),
      .rsp_channel_index  (rsp_channel_index),
      .rsp_add_rejected   (rsp_add_rejected),
      .rsp_ms_until_next  (rsp_ms_until_next),
      .rsp_any_channel    (rsp_any_channel)
   );

endmodule

`default_nettype wire
